### hdl/lnc_pkg.sv
// ----------------------------------------------------------------------------
// lnc_pkg
// Shared types, sizes and helpers of the loop nesting op coalescer: token
// and operation codes, the result word and the batch handed to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lnc_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int MAX_BLOCKS  = 4096;
   localparam int RUN_WIDTH   = 16;

   // widths that follow from the sizes above
   localparam int BLOCK_W = $clog2(MAX_BLOCKS);
   localparam int NEXT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);

   // fixed widths of the result fields
   localparam int OUT_BLOCK_W  = 12;
   localparam int OUT_AMOUNT_W = 16;

   // results one item can cause, and the result queue
   localparam int MAX_RES     = 3;
   localparam int RES_CNT_W   = 2;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = 3;
   localparam int FIFO_CW     = 4;

   localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;

   typedef enum logic [3:0] {
      TOK_NONE    = 4'd0,
      TOK_PTR_INC = 4'd1,
      TOK_PTR_DEC = 4'd2,
      TOK_VAL_INC = 4'd3,
      TOK_VAL_DEC = 4'd4,
      TOK_WRITE   = 4'd5,
      TOK_READ    = 4'd6,
      TOK_OPEN    = 4'd7,
      TOK_CLOSE   = 4'd8
   } token_type;

   typedef enum logic [3:0] {
      OP_PTR_ADD  = 4'd0,
      OP_PTR_SUB  = 4'd1,
      OP_VAL_ADD  = 4'd2,
      OP_VAL_SUB  = 4'd3,
      OP_WRITE    = 4'd4,
      OP_READ     = 4'd5,
      OP_OPEN     = 4'd6,
      OP_CLOSE    = 4'd7,
      OP_ROOT_END = 4'd8
   } op_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_NO_OPEN    = 3'd1,
      ERR_STACK_FULL = 3'd2,
      ERR_NO_IDS     = 3'd3,
      ERR_UNCLOSED   = 3'd4
   } err_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
      logic       last;
   } item_type;

   typedef struct packed {
      op_kind_type             kind;
      logic [OUT_BLOCK_W-1:0]  home_blk;
      logic [OUT_AMOUNT_W-1:0] amount;
      logic [OUT_BLOCK_W-1:0]  target;
      err_type                 err;
      logic                    last;
   } result_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]     count;
      result_type [MAX_RES-1:0] slot;
   } batch_type;

   function automatic token_type token_code(input logic [7:0] ch);
      token_type t;
      case (ch)
         8'h3e:   t = TOK_PTR_INC;
         8'h3c:   t = TOK_PTR_DEC;
         8'h2b:   t = TOK_VAL_INC;
         8'h2d:   t = TOK_VAL_DEC;
         8'h2e:   t = TOK_WRITE;
         8'h2c:   t = TOK_READ;
         8'h5b:   t = TOK_OPEN;
         8'h5d:   t = TOK_CLOSE;
         default: t = TOK_NONE;
      endcase
      return t;
   endfunction

   function automatic logic is_run_tok(input token_type t);
      return (t == TOK_PTR_INC) || (t == TOK_PTR_DEC) ||
             (t == TOK_VAL_INC) || (t == TOK_VAL_DEC);
   endfunction

   function automatic op_kind_type run_op(input token_type t);
      op_kind_type k;
      case (t)
         TOK_PTR_INC: k = OP_PTR_ADD;
         TOK_PTR_DEC: k = OP_PTR_SUB;
         TOK_VAL_INC: k = OP_VAL_ADD;
         default:     k = OP_VAL_SUB;
      endcase
      return k;
   endfunction

   function automatic result_type mk_result(input op_kind_type         kind,
                                            input logic [BLOCK_W-1:0]   blk,
                                            input logic [RUN_WIDTH-1:0] amt,
                                            input logic [BLOCK_W-1:0]   tgt,
                                            input err_type              err);
      result_type r;
      r.kind     = kind;
      r.home_blk = OUT_BLOCK_W'(blk);
      r.amount   = OUT_AMOUNT_W'(amt);
      r.target   = OUT_BLOCK_W'(tgt);
      r.err      = err;
      r.last     = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/lnc_in_reg.sv
// ----------------------------------------------------------------------------
// lnc_in_reg
// Input register: holds one source character until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lnc_in_reg
   import lnc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_in
   input  wire logic       req_tlast,
   input  wire logic       take,
   output item_type        item
);

   logic       valid_ff, valid_in;
   logic [7:0] ch_ff;
   logic       last_ff;
   logic       load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ch_ff   <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign item = '{valid: valid_ff, ch: ch_ff, last: last_ff};

endmodule

`default_nettype wire

### hdl/lnc_engine.sv
// ----------------------------------------------------------------------------
// lnc_engine
// Translation step: run merging, bracket stack and block numbering. Emits a
// batch of up to three results per character into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lnc_engine
   import lnc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  item_type  item,
   input  wire logic room,
   output logic      take,
   output batch_type batch
);

   token_type              prev_ff, prev_in;
   logic [RUN_WIDTH-1:0]   run_ff, run_in;
   logic [BLOCK_W-1:0]     cur_ff, cur_in;
   logic [NEXT_W-1:0]      next_ff, next_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic [BLOCK_W-1:0]     top_ff, top_in;
   logic [BLOCK_W-1:0]     rd_ff;
   logic [LEVEL_W-1:0]     rd_lvl;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   push;
   token_type              tok;

   // stack of enclosing blocks; the top entry is also kept in top_ff and
   // the one under it is prefetched into rd_ff
   logic [BLOCK_W-1:0] stack_mem [STACK_DEPTH];

   assign take = item.valid && room;
   assign tok  = token_code(item.ch);

   always_comb begin
      prev_in     = prev_ff;
      run_in      = run_ff;
      cur_in      = cur_ff;
      next_in     = next_ff;
      level_in    = level_ff;
      top_in      = top_ff;
      push        = 1'b0;
      batch       = '0;

      if (take) begin
         if (tok != TOK_NONE) begin
            if (is_run_tok(tok) && (tok == prev_ff)) begin
               if (run_ff == RUN_MAX) begin
                  // saturated run goes out, a fresh one starts
                  batch.slot[batch.count] = mk_result(run_op(tok), cur_ff, run_ff,
                                                      '0, ERR_NONE);
                  batch.count = batch.count + RES_CNT_W'(1);
                  run_in = RUN_WIDTH'(1);
               end else begin
                  run_in = run_ff + RUN_WIDTH'(1);
               end
            end else begin
               if (is_run_tok(prev_ff)) begin
                  batch.slot[batch.count] = mk_result(run_op(prev_ff), cur_ff, run_ff,
                                                      '0, ERR_NONE);
                  batch.count = batch.count + RES_CNT_W'(1);
               end
               run_in = RUN_WIDTH'(1);
               case (tok)
                  TOK_WRITE: begin
                     batch.slot[batch.count] = mk_result(OP_WRITE, cur_ff, '0, '0,
                                                         ERR_NONE);
                     batch.count = batch.count + RES_CNT_W'(1);
                  end
                  TOK_READ: begin
                     batch.slot[batch.count] = mk_result(OP_READ, cur_ff, '0, '0,
                                                         ERR_NONE);
                     batch.count = batch.count + RES_CNT_W'(1);
                  end
                  TOK_OPEN: begin
                     priority if (level_ff >= LEVEL_W'(STACK_DEPTH)) begin
                        batch.slot[batch.count] = mk_result(OP_OPEN, cur_ff, '0, '0,
                                                            ERR_STACK_FULL);
                     end else if (next_ff >= NEXT_W'(MAX_BLOCKS)) begin
                        batch.slot[batch.count] = mk_result(OP_OPEN, cur_ff, '0, '0,
                                                            ERR_NO_IDS);
                     end else begin
                        batch.slot[batch.count] = mk_result(OP_OPEN, cur_ff, '0,
                                                            next_ff[BLOCK_W-1:0],
                                                            ERR_NONE);
                        push     = 1'b1;
                        level_in = level_ff + LEVEL_W'(1);
                        cur_in   = next_ff[BLOCK_W-1:0];
                        next_in  = next_ff + NEXT_W'(1);
                        top_in   = cur_ff;
                     end
                     batch.count = batch.count + RES_CNT_W'(1);
                  end
                  TOK_CLOSE: begin
                     if (level_ff == '0) begin
                        batch.slot[batch.count] = mk_result(OP_CLOSE, cur_ff, '0, '0,
                                                            ERR_NO_OPEN);
                     end else begin
                        batch.slot[batch.count] = mk_result(OP_CLOSE, cur_ff, '0,
                                                            cur_ff, ERR_NONE);
                        level_in = level_ff - LEVEL_W'(1);
                        cur_in   = top_ff;
                        top_in   = rd_ff;
                     end
                     batch.count = batch.count + RES_CNT_W'(1);
                  end
                  default: begin
                  end
               endcase
            end
            prev_in = tok;
         end

         if (item.last) begin
            if (is_run_tok(prev_in)) begin
               batch.slot[batch.count] = mk_result(run_op(prev_in), cur_in, run_in,
                                                   '0, ERR_NONE);
               batch.count = batch.count + RES_CNT_W'(1);
            end
            batch.slot[batch.count] = mk_result(OP_ROOT_END, '0, '0, '0,
                                                (level_in != '0) ? ERR_UNCLOSED
                                                                 : ERR_NONE);
            batch.count = batch.count + RES_CNT_W'(1);
            prev_in  = TOK_NONE;
            run_in   = RUN_WIDTH'(1);
            cur_in   = '0;
            next_in  = NEXT_W'(1);
            level_in = '0;
         end

         if (batch.count != '0) begin
            batch.slot[batch.count - RES_CNT_W'(1)].last = 1'b1;
         end
      end
   end

   // entry under the new top, ready for the next close
   assign rd_lvl  = level_in - LEVEL_W'(2);
   assign rd_addr = rd_lvl[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= TOK_NONE;
         run_ff   <= RUN_WIDTH'(1);
         cur_ff   <= '0;
         next_ff  <= NEXT_W'(1);
         level_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         run_ff   <= run_in;
         cur_ff   <= cur_in;
         next_ff  <= next_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      rd_ff  <= stack_mem[rd_addr];
      if (push) begin
         stack_mem[level_ff[ADDR_W-1:0]] <= cur_ff;
      end
   end

endmodule

`default_nettype wire

### hdl/lnc_out_fifo.sv
// ----------------------------------------------------------------------------
// lnc_out_fifo
// Result queue: takes a batch of up to three results per cycle and hands
// them out one word per cycle while ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lnc_out_fifo
   import lnc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  batch_type  batch,
   output logic       room,
   output logic       valid,
   input  wire logic  ready,
   output result_type head
);

   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic               pop;

   result_type queue [FIFO_DEPTH];

   assign valid = count_ff != '0;
   assign pop   = valid && ready;
   assign room  = count_ff <= FIFO_CW'(FIFO_DEPTH - MAX_RES);
   assign head  = queue[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(batch.count);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(batch.count) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (RES_CNT_W'(i) < batch.count) begin
            queue[wr_ptr_ff + FIFO_AW'(i)] <= batch.slot[i];
         end
      end
   end

endmodule

`default_nettype wire

### hdl/loop_nesting_op_coalescer.sv
// ----------------------------------------------------------------------------
// loop_nesting_op_coalescer
// Run-length translator for the eight-token tape language: merges repeated
// pointer and value steps, numbers loop blocks with a bracket stack.
//
//   channel  dir  tdata                               tuser    tlast
//   req      in   char_in[7:0]                        -        end_of_source
//   rsp      out  home_blk, amount, target, error     op_kind  last_of_batch
//
// one character per cycle while each causes at most one word; characters
// that cause two or three words are absorbed by an 8-entry result queue
// that drains one word per cycle, so the sustained rate is set by the
// number of words produced on the rsp side
// reset clears all control state; the block stack memory and its top registers are not cleared
// a stalled rsp side fills the queue and then holds req_tready low
// ----------------------------------------------------------------------------
`default_nettype none

module loop_nesting_op_coalescer
   import lnc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [11:0] home_blk, [27:12] amount,
                                         // [39:28] target_block, [42:40] error_code
   output logic [3:0]       rsp_tuser,   // [3:0] op_kind
   output logic             rsp_tlast
);

   item_type   item;
   batch_type  batch;
   result_type head;
   logic       take;
   logic       room;

   lnc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .item       (item)
   );

   lnc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .item  (item),
      .room  (room),
      .take  (take),
      .batch (batch)
   );

   lnc_out_fifo u_out_fifo (
      .clock (clock),
      .reset (reset),
      .batch (batch),
      .room  (room),
      .valid (rsp_tvalid),
      .ready (rsp_tready),
      .head  (head)
   );

   assign rsp_tdata = {5'b0, head.err, head.target, head.amount, head.home_blk};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire

### hdl/lnc_checker.sv
// ----------------------------------------------------------------------------
// lnc_checker
// Port-level checks of the coalescer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lnc_checker
   import lnc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // root end closes the item and carries no block, amount or target
   a_root_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == OP_ROOT_END) |->
         rsp_tlast && (rsp_tdata[11:0] == '0) && (rsp_tdata[27:12] == '0) &&
         (rsp_tdata[39:28] == '0))
      else $error("malformed root end word");

   a_run_ops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == OP_PTR_ADD) || (rsp_tuser == OP_PTR_SUB) ||
                     (rsp_tuser == OP_VAL_ADD) || (rsp_tuser == OP_VAL_SUB)) |->
         (rsp_tdata[42:40] == ERR_NONE) && (rsp_tdata[39:28] == '0))
      else $error("run word with target or error");

   a_io_ops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == OP_WRITE) || (rsp_tuser == OP_READ)) |->
         (rsp_tdata[27:12] == '0) && (rsp_tdata[39:28] == '0) &&
         (rsp_tdata[42:40] == ERR_NONE))
      else $error("io word with amount, target or error");

endmodule

bind loop_nesting_op_coalescer lnc_checker u_checker (.*);

`default_nettype wire
